>>> hdl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define CPS_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define CPS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/cps_pkg.sv
package cps_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int T_BITS      = 32;
    localparam int DIST_FRAC   = 32;
    localparam int DIST_WIDTH  = 64;
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
    localparam int DOT_WIDTH   = PROD_WIDTH + 2;
    localparam int CNT_WIDTH   = $clog2(T_BITS + 1);

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
    typedef logic signed [DOT_WIDTH-1:0]   dot_t;

    typedef struct packed {
        coord_t point_x;
        coord_t point_y;
        coord_t point_z;
        coord_t start_x;
        coord_t start_y;
        coord_t start_z;
        coord_t end_x;
        coord_t end_y;
        coord_t end_z;
        logic   last_segment;
    } seg_in_t;

    typedef struct packed {
        coord_t                near_x;
        coord_t                near_y;
        coord_t                near_z;
        logic [DIST_WIDTH-1:0] dist_squared;
        logic                  found;
    } seg_out_t;

    // datapath operation selects
    typedef enum logic [3:0] {
        OP_NONE   = 4'd0,
        OP_LOAD   = 4'd1,
        OP_MULA   = 4'd2,
        OP_MULB   = 4'd3,
        OP_MULC   = 4'd4,
        OP_CLASS  = 4'd5,
        OP_DIV    = 4'd6,
        OP_OFF    = 4'd7,
        OP_DIFF   = 4'd8,
        OP_SQ     = 4'd9,
        OP_UPDATE = 4'd10,
        OP_CLEAR  = 4'd11
    } dp_op_t;

    typedef struct packed {
        dp_op_t                  op;
        logic [1:0]              axis;
    } dp_cmd_t;

    typedef struct packed {
        logic degenerate;
        logic clamp;
        logic div_done;
    } dp_stat_t;

endpackage

>>> hdl/cps_datapath.sv
module cps_datapath
    import cps_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  seg_in_t  in_data,
    input  dp_cmd_t  cmd,
    output dp_stat_t stat,
    output seg_out_t result
);

    `include "assert_macros.svh"

    diff_t p_reg [3];
    diff_t a_reg [3];
    diff_t at_reg [3];
    diff_t ab_reg [3];
    diff_t d_reg [3];
    diff_t c_reg [3];
    dot_t  num_reg, den_reg, sq_reg;
    logic [DOT_WIDTH:0] rem_reg;
    logic [T_BITS-1:0]  q_reg;
    logic [CNT_WIDTH-1:0] cnt_reg;
    logic  clamp_reg;
    coord_t best_reg [3];
    logic [DIST_WIDTH-1:0] best_dist_reg;
    logic  have_best_reg;

    diff_t mul_a, mul_b;
    logic signed [PROD_WIDTH-1:0] prod;
    logic signed [PROD_WIDTH+T_BITS:0] off_prod;
    logic signed [PROD_WIDTH+T_BITS:0] off_rnd;
    logic [DOT_WIDTH:0] rem_sh;
    logic [DIST_WIDTH-1:0] cand_dist;
    dot_t sq_shift;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_MULA: begin mul_a = ab_reg[cmd.axis]; mul_b = ab_reg[cmd.axis]; end
            OP_MULB: begin mul_a = at_reg[cmd.axis]; mul_b = ab_reg[cmd.axis]; end
            OP_SQ:   begin mul_a = d_reg[cmd.axis];  mul_b = d_reg[cmd.axis];  end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end
    assign prod     = PROD_WIDTH'(mul_a) * PROD_WIDTH'(mul_b);
    assign off_prod = (PROD_WIDTH+T_BITS+1)'(ab_reg[cmd.axis])
                    * $signed({1'b0, q_reg});
    assign off_rnd  = off_prod + (PROD_WIDTH+T_BITS+1)'(64'd1 << (T_BITS - 1));
    assign rem_sh   = {rem_reg[DOT_WIDTH-1:0], 1'b0};

    // q16.16 squared has 2*frac fraction bits, bring to 32
    always_comb begin
        if (2 * FRAC_BITS >= DIST_FRAC) sq_shift = sq_reg >>> (2 * FRAC_BITS - DIST_FRAC);
        else                            sq_shift = sq_reg <<< (DIST_FRAC - 2 * FRAC_BITS);
        if (sq_shift[DOT_WIDTH-1:DIST_WIDTH] != '0) cand_dist = '1;
        else                                        cand_dist = sq_shift[DIST_WIDTH-1:0];
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_LOAD: begin
                p_reg[0]  <= DIFF_WIDTH'(in_data.point_x);
                p_reg[1]  <= DIFF_WIDTH'(in_data.point_y);
                p_reg[2]  <= DIFF_WIDTH'(in_data.point_z);
                a_reg[0]  <= DIFF_WIDTH'(in_data.start_x);
                a_reg[1]  <= DIFF_WIDTH'(in_data.start_y);
                a_reg[2]  <= DIFF_WIDTH'(in_data.start_z);
                at_reg[0] <= DIFF_WIDTH'(in_data.point_x) - DIFF_WIDTH'(in_data.start_x);
                at_reg[1] <= DIFF_WIDTH'(in_data.point_y) - DIFF_WIDTH'(in_data.start_y);
                at_reg[2] <= DIFF_WIDTH'(in_data.point_z) - DIFF_WIDTH'(in_data.start_z);
                ab_reg[0] <= DIFF_WIDTH'(in_data.end_x) - DIFF_WIDTH'(in_data.start_x);
                ab_reg[1] <= DIFF_WIDTH'(in_data.end_y) - DIFF_WIDTH'(in_data.start_y);
                ab_reg[2] <= DIFF_WIDTH'(in_data.end_z) - DIFF_WIDTH'(in_data.start_z);
                num_reg   <= '0;
                den_reg   <= '0;
                sq_reg    <= '0;
            end
            OP_MULA: den_reg <= den_reg + DOT_WIDTH'(prod);
            OP_MULB: num_reg <= num_reg + DOT_WIDTH'(prod);
            OP_SQ:   sq_reg  <= sq_reg + DOT_WIDTH'(prod);
            OP_CLASS: begin
                rem_reg <= (DOT_WIDTH+1)'(num_reg);
                q_reg   <= '0;
                cnt_reg <= '0;
                for (int i = 0; i < 3; i++) begin
                    if (num_reg <= 0)           c_reg[i] <= a_reg[i];
                    else                        c_reg[i] <= a_reg[i] + ab_reg[i];
                end
                clamp_reg <= (num_reg <= 0) || (num_reg >= den_reg);
            end
            OP_DIV: begin
                cnt_reg <= cnt_reg + 1'b1;
                if (rem_sh >= (DOT_WIDTH+1)'(den_reg)) begin
                    rem_reg <= rem_sh - (DOT_WIDTH+1)'(den_reg);
                    q_reg   <= {q_reg[T_BITS-2:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh;
                    q_reg   <= {q_reg[T_BITS-2:0], 1'b0};
                end
            end
            OP_OFF: c_reg[cmd.axis] <= a_reg[cmd.axis]
                                    + DIFF_WIDTH'(off_rnd >>> T_BITS);
            OP_DIFF: for (int i = 0; i < 3; i++)
                d_reg[i] <= p_reg[i] - c_reg[i];
            default: ;
        endcase
    end

    // best-so-far state
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.op == OP_CLEAR) begin
            have_best_reg <= 1'b0;
            best_dist_reg <= '1;
            for (int i = 0; i < 3; i++) best_reg[i] <= '0;
        end else if (cmd.op == OP_UPDATE) begin
            if (!have_best_reg || cand_dist < best_dist_reg) begin
                have_best_reg <= 1'b1;
                best_dist_reg <= cand_dist;
                for (int i = 0; i < 3; i++) best_reg[i] <= c_reg[i][COORD_WIDTH-1:0];
            end
        end
    end

    assign stat.degenerate = (den_reg == '0);
    assign stat.clamp      = clamp_reg;
    assign stat.div_done   = (cnt_reg == CNT_WIDTH'(T_BITS));

    assign result.near_x       = best_reg[0];
    assign result.near_y       = best_reg[1];
    assign result.near_z       = best_reg[2];
    assign result.dist_squared = best_dist_reg;
    assign result.found        = have_best_reg;

    `CPS_ASSERT_NEXT(a_clear_empties, aclk, aresetn, cmd.op == OP_CLEAR,
        !have_best_reg && best_dist_reg == '1, "clear left best state")
    `CPS_ASSERT_IMPL(a_empty_max, aclk, aresetn, !have_best_reg,
        best_dist_reg == '1, "empty best without max distance")
    `CPS_ASSERT_NEXT(a_update_sets, aclk, aresetn, cmd.op == OP_UPDATE,
        have_best_reg, "update left no best")

endmodule

>>> hdl/cps_ctrl.sv
module cps_ctrl
    import cps_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  logic     last_segment,
    input  dp_stat_t stat,
    input  logic     out_full,
    output dp_cmd_t  cmd,
    output logic     out_load
);

    `include "assert_macros.svh"

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_MULA  = 10'b0000000010,
        ST_MULB  = 10'b0000000100,
        ST_CLASS = 10'b0000001000,
        ST_DIV   = 10'b0000010000,
        ST_OFF   = 10'b0000100000,
        ST_DIFF  = 10'b0001000000,
        ST_SQ    = 10'b0010000000,
        ST_UPD   = 10'b0100000000,
        ST_EMIT  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic last_reg;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        axis_next  = axis_reg;
        cmd.op     = OP_NONE;
        cmd.axis   = axis_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: if (s_valid) begin
                cmd.op = OP_LOAD; axis_next = '0; state_next = ST_MULA;
            end
            ST_MULA: begin
                cmd.op = OP_MULA;
                if (axis_reg == 2'd2) begin axis_next = '0; state_next = ST_MULB; end
                else axis_next = axis_reg + 1'b1;
            end
            ST_MULB: begin
                cmd.op = OP_MULB;
                if (axis_reg == 2'd2) begin axis_next = '0; state_next = ST_CLASS; end
                else axis_next = axis_reg + 1'b1;
            end
            ST_CLASS: begin
                if (stat.degenerate) state_next = ST_EMIT;
                else begin cmd.op = OP_CLASS; state_next = ST_DIV; end
            end
            ST_DIV: begin
                if (stat.clamp) state_next = ST_DIFF;
                else if (stat.div_done) begin axis_next = '0; state_next = ST_OFF; end
                else cmd.op = OP_DIV;
            end
            ST_OFF: begin
                cmd.op = OP_OFF;
                if (axis_reg == 2'd2) state_next = ST_DIFF;
                else axis_next = axis_reg + 1'b1;
            end
            ST_DIFF: begin cmd.op = OP_DIFF; axis_next = '0; state_next = ST_SQ; end
            ST_SQ: begin
                cmd.op = OP_SQ;
                if (axis_reg == 2'd2) state_next = ST_UPD;
                else axis_next = axis_reg + 1'b1;
            end
            ST_UPD:  begin cmd.op = OP_UPDATE; state_next = ST_EMIT; end
            ST_EMIT: begin
                if (!last_reg) state_next = ST_IDLE;
                else if (!out_full) begin
                    out_load = 1'b1; cmd.op = OP_CLEAR; state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            axis_reg  <= '0;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            if (s_valid && s_ready) last_reg <= last_segment;
        end
    end

    `CPS_ASSERT_IMPL(a_onehot, aclk, aresetn, 1'b1, $onehot(state_reg), "state not one-hot")
    `CPS_ASSERT_IMPL(a_emit_last, aclk, aresetn, out_load, last_reg, "result without last")
    `CPS_ASSERT_NEXT(a_accept_busy, aclk, aresetn, s_valid && s_ready,
        !s_ready, "second beat taken while busy")

endmodule

>>> hdl/closest_point_on_segments_top.sv
// Running nearest point of a query point to a stream of 3D segments. Each input
// beat carries the query point and one segment (signed Q16.16); on the beat
// flagged last_segment one result beat gives the best point, its squared
// distance (Q32.32, saturating) and a found flag, and the state clears. A
// zero-length segment is skipped once the dot products are formed, a projection
// that clamps to an end skips the division, and otherwise the projection
// fraction is needed: a shared multiplier works one axis a cycle and a
// restoring divider gives the 32-bit fraction one quotient bit a cycle. A
// new beat is taken only once the previous one is finished; the result sits in
// an output register so the input side does not wait for the result to be
// taken, except that a new result waits for the previous one to drain.
module closest_point_on_segments_top
    import cps_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  seg_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output seg_out_t m_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;
    seg_out_t result;
    logic     out_load;
    logic     out_full;
    logic     m_valid_reg;
    seg_out_t m_data_reg;

    // a new result must wait while the previous one is still undrained
    assign out_full = m_valid_reg && !m_ready;

    cps_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .last_segment (s_data.last_segment),
        .stat         (stat),
        .out_full     (out_full),
        .cmd          (cmd),
        .out_load     (out_load)
    );

    cps_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_data (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .result  (result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_reg <= 1'b0;
        else if (out_load) m_valid_reg <= 1'b1;
        else if (m_ready) m_valid_reg <= 1'b0;
        if (out_load) m_data_reg <= result;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
